// ===== sv/b64sc_pkg.sv =====
// ============================================================================
// b64sc_pkg
// Shared types, constants and character helpers for the Base64 stream codec.
// ============================================================================
`default_nettype none

package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam logic [7:0] CODE_PAD     = 8'hFE;
    localparam logic [7:0] CODE_INVALID = 8'hFF;

    typedef struct packed {
        logic [3:0][7:0] bytes;     // bytes[0] goes out first
        logic [1:0]      last_idx;  // number of results minus one
        logic            marker;    // empty end marker
        logic            last;      // request ends its string
        logic            halted;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

    function automatic logic [7:0] dec_code(input logic [7:0] ch);
        logic [7:0] r;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            r = ch - 8'h41;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            r = ch - 8'h61 + 8'd26;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            r = ch - 8'h30 + 8'd52;
        end else if (ch == 8'h2B) begin
            r = 8'd62;
        end else if (ch == 8'h2F) begin
            r = 8'd63;
        end else if (ch == PAD_CHAR) begin
            r = CODE_PAD;
        end else begin
            r = CODE_INVALID;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/b64sc_front.sv =====
// ============================================================================
// b64sc_front
// Accepts input bytes, keeps the pending group and turns each completed
// group that yields results, or each string end, into one output request for the queue.
// ============================================================================
`default_nettype none

module b64sc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_wr_data,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_is_last,
    output logic                  o_push,
    output b64sc_pkg::t_job       o_job
);

    logic        r_mode;
    logic [23:0] r_hold;
    logic [1:0]  r_cnt;
    logic        r_halted;

    logic [23:0] n_hold;
    logic [1:0]  n_cnt;
    logic        n_halted;

    logic [7:0]  w_item;
    logic [23:0] w_hold_ins;
    logic [2:0]  w_n1;
    logic [7:0]  w_a;
    logic [7:0]  w_b;
    logic [7:0]  w_c;
    logic [7:0]  w_d;
    logic [7:0]  w_x0;
    logic [7:0]  w_x1;
    logic [7:0]  w_x2;
    logic [2:0]  w_k;
    logic        w_grp;
    logic        w_halt_grp;

    assign w_item = r_mode ? b64sc_pkg::dec_code(i_data_byte) : i_data_byte;
    assign w_n1   = {1'b0, r_cnt} + 3'd1;

    always_comb begin
        case (r_cnt)
            2'd0:    w_hold_ins = r_hold | {w_item, 16'h0000};
            2'd1:    w_hold_ins = r_hold | {8'h00, w_item, 8'h00};
            2'd2:    w_hold_ins = r_hold | {16'h0000, w_item};
            default: w_hold_ins = r_hold;
        endcase
    end

    // decode group operands
    always_comb begin
        if (r_cnt == 2'd3) begin
            w_a = r_hold[23:16];
            w_b = r_hold[15:8];
            w_c = r_hold[7:0];
            w_d = w_item;
        end else begin
            w_a = w_hold_ins[23:16];
            w_b = (w_n1 >= 3'd2) ? w_hold_ins[15:8] : b64sc_pkg::CODE_INVALID;
            w_c = (w_n1 >= 3'd3) ? w_hold_ins[7:0] : b64sc_pkg::CODE_PAD;
            w_d = b64sc_pkg::CODE_PAD;
        end
    end

    assign w_x0 = {w_a[5:0], w_b[5:4]};
    assign w_x1 = {w_b[3:0], w_c[5:2]};
    assign w_x2 = {w_c[1:0], w_d[5:0]};
    assign w_halt_grp = w_a[7] | w_b[7];

    always_comb begin
        n_hold      = r_hold;
        n_cnt       = r_cnt;
        n_halted    = r_halted;
        w_grp       = 1'b0;
        w_k         = 3'd0;
        o_job.bytes = '0;
        if (!r_mode) begin
            n_hold = w_hold_ins;
            n_cnt  = w_n1[1:0];
            if (w_n1 == 3'd3 || i_is_last) begin
                w_k         = 3'd4;
                o_job.bytes[0] = b64sc_pkg::enc_char(w_hold_ins[23:18]);
                o_job.bytes[1] = b64sc_pkg::enc_char(w_hold_ins[17:12]);
                o_job.bytes[2] = (w_n1 >= 3'd2) ? b64sc_pkg::enc_char(w_hold_ins[11:6])
                                                : b64sc_pkg::PAD_CHAR;
                o_job.bytes[3] = (w_n1 >= 3'd3) ? b64sc_pkg::enc_char(w_hold_ins[5:0])
                                                : b64sc_pkg::PAD_CHAR;
                n_hold = '0;
                n_cnt  = 2'd0;
            end
        end else if (!r_halted) begin
            if (r_cnt == 2'd3) begin
                w_grp  = 1'b1;
                n_hold = '0;
                n_cnt  = 2'd0;
            end else begin
                n_hold = w_hold_ins;
                n_cnt  = w_n1[1:0];
                w_grp  = i_is_last;
            end
            if (w_grp) begin
                if (w_halt_grp) begin
                    n_halted = 1'b1;
                end else begin
                    w_k = 3'd1 + {2'b00, ~w_c[7]} + {2'b00, ~w_d[7]};
                    o_job.bytes[0] = w_x0;
                    o_job.bytes[1] = w_c[7] ? w_x2 : w_x1;
                    o_job.bytes[2] = w_x2;
                end
            end
        end
        o_job.marker   = (w_k == 3'd0);
        o_job.last_idx = (w_k == 3'd0) ? 2'd0 : 2'(w_k - 3'd1);
        o_job.last     = i_is_last;
        o_job.halted   = n_halted;
        o_push         = i_accept && (i_is_last || w_k != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_hold   <= '0;
            r_cnt    <= 2'd0;
            r_halted <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode   <= i_cfg_wr_data;
            r_hold   <= '0;
            r_cnt    <= 2'd0;
            r_halted <= 1'b0;
        end else if (i_accept) begin
            if (i_is_last) begin
                r_hold   <= '0;
                r_cnt    <= 2'd0;
                r_halted <= 1'b0;
            end else begin
                r_hold   <= n_hold;
                r_cnt    <= n_cnt;
                r_halted <= n_halted;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64sc_queue.sv =====
// ============================================================================
// b64sc_queue
// Small request queue between the front and the output serializer.
// ============================================================================
`default_nettype none

module b64sc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire b64sc_pkg::t_job       i_job,
    input  wire logic                  i_pop,
    output b64sc_pkg::t_job            o_head,
    output b64sc_pkg::t_q_stat         o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64sc_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64sc_back.sv =====
// ============================================================================
// b64sc_back
// Takes requests from the queue and sends their results one per cycle
// while i_stall is low, through a registered output stage.
// ============================================================================
`default_nettype none

module b64sc_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire b64sc_pkg::t_job       i_head,
    input  wire b64sc_pkg::t_q_stat    i_stat,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_out_valid,
    output logic                       o_out_last,
    output logic                       o_decode_halted
);

    b64sc_pkg::t_job r_job;
    logic [1:0]      r_idx;
    logic            r_busy;
    logic            r_ovalid;
    logic [7:0]      r_obyte;
    logic            r_ovld;
    logic            r_olast;
    logic            r_ohalt;

    logic w_load;
    logic w_fin;
    logic w_take;

    assign w_load = !r_ovalid || !i_stall;
    assign w_fin  = r_busy && w_load && (r_idx == r_job.last_idx);
    assign w_take = !r_busy || w_fin;
    assign o_pop  = w_take && !i_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_job  <= i_head;
            r_idx  <= 2'd0;
            r_busy <= 1'b1;
        end else if (w_take) begin
            r_busy <= 1'b0;
        end else if (r_busy && w_load) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && r_busy) begin
            r_obyte <= r_job.bytes[r_idx];
            r_ovld  <= !r_job.marker;
            r_olast <= r_job.last && (r_idx == r_job.last_idx);
            r_ohalt <= r_job.halted;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_out_byte      = r_obyte;
    assign o_out_valid     = r_ovld;
    assign o_out_last      = r_olast;
    assign o_decode_halted = r_ohalt;

endmodule

`default_nettype wire

// ===== sv/base64_stream_codec_core.sv =====
// ============================================================================
// base64_stream_codec_core
// Streaming Base64 encoder/decoder: one byte in per input transfer, up to four
// result bytes out per request.
// ============================================================================
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  input   | i_valid / o_stall  | i_data_byte, i_is_last
//  output  | o_valid / i_stall  | o_out_byte, o_out_valid, o_out_last,
//          |                    | o_decode_halted
//  config  | i_cfg_wr_en        | i_cfg_wr_data (decode mode)
//
//  Input takes one byte per cycle while the request queue has room.
//  Output sends one result per cycle while i_stall is low; encode gives four
//  per three bytes, so in encode the serializer, not the input, limits throughput.
//  The first result of a completed group passes the queue, the serializer's job register and the output register.
//  Synchronous active-low reset clears mode, group state, queue and output valid.
//  o_stall is the queue-full flag; i_stall holds the output register and the serializer's progress through a request.
// ============================================================================
`default_nettype none

module base64_stream_codec_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_is_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_valid,
    output logic            o_out_last,
    output logic            o_decode_halted
);

    logic                w_accept;
    logic                w_push;
    logic                w_pop;
    b64sc_pkg::t_job     w_job;
    b64sc_pkg::t_job     w_head;
    b64sc_pkg::t_q_stat  w_stat;

    assign o_stall  = w_stat.full;
    assign w_accept = i_valid && !w_stat.full;

    b64sc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_is_last     (i_is_last),
        .o_push        (w_push),
        .o_job         (w_job)
    );

    b64sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    b64sc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_stat          (w_stat),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_out_valid     (o_out_valid),
        .o_out_last      (o_out_last),
        .o_decode_halted (o_decode_halted)
    );

    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_stat.full))
        else $error("request pushed into a full queue");

    a_marker_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> o_out_last)
        else $error("end marker without last flag");

    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_pop_needs_entry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire
